// ===== sv/rv32_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32_pkg
// Shared types and constants for the RV32IM execute block.
// ----------------------------------------------------------------------------
package rv32_pkg;

	localparam int unsigned REG_COUNT = 32;
	localparam int unsigned REG_AW = $clog2(REG_COUNT);

	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] F7_ALT     = 7'h20;
	localparam logic [6:0] F7_MULDIV  = 7'h01;

	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_STORE = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [31:0] instruction;
		logic [31:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] fetch_address;
		logic [1:0]  mem_request;
		logic [31:0] mem_address;
		logic [1:0]  mem_size;
		logic [31:0] store_data;
		logic        trap;
		logic [31:0] call_code;
		logic [31:0] call_argument;
	} out_item_t;

	// Request to the shared multiply/divide unit.
	typedef struct packed {
		logic        start;
		logic [2:0]  funct3;
		logic [31:0] a;
		logic [31:0] b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} md_rsp_t;

endpackage

// ===== sv/rv32im_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// rv32im_instruction_execute
// Multicycle RV32IM execute block with register file and program counter.
// ----------------------------------------------------------------------------
//  Channel   Signals                         Direction  Moves
//  input     in_valid / in_ready / in_item    in         instruction or load beat
//  output    out_valid / out_ready / out_item out        one result beat per input
//  config    cfg_we / cfg_wdata               in         start address write
//
// After an instruction beat is accepted, RD1 addresses rs1 (or a7 for a
// trap), RD2 addresses rs2 (or a0) while rs1 data arrives, and EXEC then
// registers rs2 while rdsel_q is low and, once rdsel_q is set, computes the
// result and writes the register file. The result beat is then offered in
// the OUT state. A load return beat passes through the LDWB state before its
// result beat is offered. MUL and DIV variants wait in the MD state for the
// shared iterative unit, which writes their result. The block is not ready
// again until the cycle after its result beat has been taken. Reset clears
// the pc, the pending load and the register file valid bits, so every register
// reads as zero until written.
module rv32im_instruction_execute (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rv32_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rv32_pkg::out_item_t   out_item,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata
);
	import rv32_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD1  = 7'b0000010,
		ST_RD2  = 7'b0000100,
		ST_EXEC = 7'b0001000,
		ST_MD   = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_LDWB = 7'b1000000
	} state_t;

	state_t          state_q;
	in_item_t        item_q;
	logic [31:0]     pc_q;
	logic [7:0]      pend_q;
	logic            await_q;
	logic [REG_COUNT-1:0] vld_q;
	logic [31:0]     a_q;
	logic [31:0]     b_q;
	logic [31:0]     a7_q;
	logic [31:0]     a0_q;
	out_item_t       out_q;
	logic            rdsel_q;

	// Register file RAM signals.
	logic            rf_we;
	logic [REG_AW-1:0] rf_waddr;
	logic [31:0]     rf_wdata;
	logic [REG_AW-1:0] rf_raddr;
	logic [31:0]     rf_rdata;
	logic [4:0]      rd_idx;
	logic [4:0]      rs_idx;
	logic            rs_ok;
	logic [31:0]     rs_val;
	logic [REG_AW-1:0] rf_raddr_q;
	logic              rs_ok_q;

	md_req_t         md_req;
	md_rsp_t         md_rsp;

	// Decoded fields.
	logic [31:0] ins;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] immi;
	logic [31:0] imms;
	logic [31:0] immb;
	logic [31:0] immj;
	logic [31:0] alu_b;
	logic        alt;
	logic [31:0] alu_y;
	logic        take;
	logic        wr_en;
	logic [31:0] wr_val;
	out_item_t   res;
	logic [31:0] ld_val;

	assign ins  = item_q.instruction;
	assign opc  = ins[6:0];
	assign rd   = ins[11:7];
	assign f3   = ins[14:12];
	assign f7   = ins[31:25];
	assign immi = {{20{ins[31]}}, ins[31:20]};
	assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
	assign immb = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
	assign immj = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};

	// The read port walks rs1 then rs2. For a trap, a7 and a0 take those two
	// read slots instead.
	always_comb begin
		rs_idx = 5'd0;
		unique case (state_q)
			ST_RD1:  rs_idx = ins[19:15];
			ST_RD2:  rs_idx = ins[24:20];
			default: rs_idx = ins[19:15];
		endcase
		if (opc == OPC_SYSTEM) begin
			rs_idx = (state_q == ST_RD1) ? 5'd17 : 5'd10;
		end
	end

	// Indexes beyond the implemented file read as zero.
	assign rs_ok    = (32'(rs_idx) < REG_COUNT) && (rs_idx != 5'd0);
	assign rf_raddr = rs_idx[REG_AW-1:0];
	assign rs_val   = (vld_q[rf_raddr_q] && rs_ok_q) ? rf_rdata : 32'd0;

	always_ff @(posedge clk) begin
		rf_raddr_q <= rf_raddr;
		rs_ok_q    <= rs_ok;
	end

	always_comb begin
		alt = 1'b0;
		alu_b = b_q;
		if (opc == OPC_OPIMM) begin
			alu_b = immi;
			alt = (f3 == 3'd5) && ins[30];
		end else begin
			alt = (f7 == F7_ALT) && (f3 == 3'd0 || f3 == 3'd5);
		end
		unique case (f3)
			3'd0: alu_y = alt ? (a_q - alu_b) : (a_q + alu_b);
			3'd1: alu_y = a_q << alu_b[4:0];
			3'd2: alu_y = {31'd0, $signed(a_q) < $signed(alu_b)};
			3'd3: alu_y = {31'd0, a_q < alu_b};
			3'd4: alu_y = a_q ^ alu_b;
			3'd5: alu_y = alt ? 32'($signed(a_q) >>> alu_b[4:0]) : (a_q >> alu_b[4:0]);
			3'd6: alu_y = a_q | alu_b;
			default: alu_y = a_q & alu_b;
		endcase
		unique case (f3)
			3'd0: take = (a_q == b_q);
			3'd1: take = (a_q != b_q);
			3'd4: take = $signed(a_q) < $signed(b_q);
			3'd5: take = !($signed(a_q) < $signed(b_q));
			3'd6: take = a_q < b_q;
			3'd7: take = a_q >= b_q;
			default: take = 1'b0;
		endcase
	end

	// Execute stage result and register writeback.
	always_comb begin
		res = '0;
		res.fetch_address = pc_q + 32'd4;
		wr_en = 1'b0;
		wr_val = alu_y;
		unique case (opc)
			OPC_SYSTEM: begin
				res.trap = 1'b1;
				res.call_code = a7_q;
				res.call_argument = a0_q;
			end
			OPC_LUI: begin
				wr_en = 1'b1;
				wr_val = {ins[31:12], 12'd0};
			end
			OPC_AUIPC: begin
				wr_en = 1'b1;
				wr_val = {ins[31:12], 12'd0} + pc_q;
			end
			OPC_JAL: begin
				wr_en = 1'b1;
				wr_val = pc_q + 32'd4;
				res.fetch_address = pc_q + immj;
			end
			OPC_JALR: begin
				wr_en = 1'b1;
				wr_val = pc_q + 32'd4;
				res.fetch_address = (a_q + immi) & ~32'd1;
			end
			OPC_BRANCH: begin
				if (take) begin
					res.fetch_address = pc_q + immb;
				end
			end
			OPC_LOAD: begin
				if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5) begin
					res.mem_request = REQ_LOAD;
					res.mem_address = a_q + immi;
					res.mem_size = {1'b0, f3[1:0]} == 3'd3 ? 2'd0 : f3[1:0];
				end
			end
			OPC_STORE: begin
				if (f3 <= 3'd2) begin
					res.mem_request = REQ_STORE;
					res.mem_address = a_q + imms;
					res.mem_size = f3[1:0];
					res.store_data = b_q;
				end
			end
			OPC_OPIMM: wr_en = 1'b1;
			OPC_OP: wr_en = (f7 != F7_MULDIV);
			default: ;
		endcase
	end

	always_comb begin
		unique case (pend_q[7:5])
			3'd0: ld_val = {{24{item_q.load_data[7]}}, item_q.load_data[7:0]};
			3'd1: ld_val = {{16{item_q.load_data[15]}}, item_q.load_data[15:0]};
			3'd4: ld_val = {24'd0, item_q.load_data[7:0]};
			3'd5: ld_val = {16'd0, item_q.load_data[15:0]};
			default: ld_val = item_q.load_data;
		endcase
	end

	// Register file write selection. Execute writes only once rdsel_q is set,
	// when both operands are in place.
	always_comb begin
		rf_we = 1'b0;
		rd_idx = rd;
		rf_wdata = wr_val;
		unique case (state_q)
			ST_EXEC: rf_we = wr_en && rdsel_q;
			ST_MD: begin
				rf_we = md_rsp.done;
				rf_wdata = md_rsp.result;
			end
			ST_LDWB: begin
				rf_we = await_q;
				rd_idx = pend_q[4:0];
				rf_wdata = ld_val;
			end
			default: ;
		endcase
		if (rd_idx == 5'd0 || 32'(rd_idx) >= REG_COUNT) begin
			rf_we = 1'b0;
		end
	end
	assign rf_waddr = rd_idx[REG_AW-1:0];

	assign md_req.start  = (state_q == ST_EXEC) && rdsel_q && (opc == OPC_OP) &&
		(f7 == F7_MULDIV);
	assign md_req.funct3 = f3;
	assign md_req.a      = a_q;
	assign md_req.b      = b_q;

	rv32_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	rv32_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= 32'd0;
			pend_q  <= '0;
			await_q <= 1'b0;
			vld_q   <= '0;
			rdsel_q <= 1'b0;
		end else begin
			if (rf_we) begin
				vld_q[rf_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						pc_q <= cfg_wdata;
					end
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= in_item.operation ? ST_LDWB : ST_RD1;
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					// rs1 (or a7) data is now on the RAM output.
					a_q  <= rs_val;
					a7_q <= rs_val;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					b_q  <= rs_val;
					a0_q <= rs_val;
					rdsel_q <= ~rdsel_q;
					if (!rdsel_q) begin
						// Stay in EXEC so b_q is in place for execute.
						state_q <= ST_EXEC;
					end else begin
						await_q <= 1'b0;
						if (res.mem_request == REQ_LOAD) begin
							await_q <= 1'b1;
							pend_q  <= {f3, rd};
						end
						out_q <= res;
						pc_q  <= res.fetch_address;
						state_q <= md_req.start ? ST_MD : ST_OUT;
					end
				end
				ST_MD: begin
					if (md_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_LDWB: begin
					await_q <= 1'b0;
					out_q <= '0;
					out_q.fetch_address <= pc_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/rv32_ram.sv =====
// ----------------------------------------------------------------------------
// rv32_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rv32_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/rv32_muldiv.sv =====
// ----------------------------------------------------------------------------
// rv32_muldiv
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module rv32_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  rv32_pkg::md_req_t req,
	output rv32_pkg::md_rsp_t rsp
);
	import rv32_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [2:0]  f3_q;
	logic [63:0] acc_q;
	logic [63:0] mcand_q;
	logic [31:0] mplier_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        negq_q;
	logic        negr_q;
	logic        bneg_q;
	logic [31:0] a_q;
	logic        bzero_q;
	logic        done_q;
	logic [31:0] res_q;

	logic        a_neg;
	logic        b_neg;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] ea;
	logic [33:0] trial;
	logic [32:0] rem_sh;
	logic        is_div;

	always_comb begin
		is_div = req.funct3[2];
		a_neg = req.a[31] && (req.funct3 == 3'd1 || req.funct3 == 3'd2 ||
			req.funct3 == 3'd4 || req.funct3 == 3'd6);
		b_neg = req.b[31] && (req.funct3 == 3'd1 || req.funct3 == 3'd4 ||
			req.funct3 == 3'd6);
		ma = a_neg ? (32'd0 - req.a) : req.a;
		mb = b_neg ? (32'd0 - req.b) : req.b;
		ea = {{32{a_neg}}, req.a};
		rem_sh = {rem_q, quo_q[31]};
		trial = {1'b0, rem_sh} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				f3_q    <= req.funct3;
				a_q     <= req.a;
				bzero_q <= (req.b == 32'd0);
				acc_q   <= '0;
				// Sign-extended 64-bit multiply keeps the low 64 bits exact.
				mcand_q <= is_div ? 64'd0 : ea;
				mplier_q <= is_div ? 32'd0 : req.b;
				rem_q   <= '0;
				quo_q   <= ma;
				dvs_q   <= mb;
				negq_q  <= a_neg ^ b_neg;
				negr_q  <= a_neg;
				bneg_q  <= b_neg;
			end else if (busy_q) begin
				if (!f3_q[2]) begin
					// Multiply: sign of b adds a subtract of a<<32 at the end.
					if (cnt_q[5]) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						if (f3_q == 3'd1 && bneg_q) begin
							res_q <= acc_q[63:32] - a_q;
						end else begin
							res_q <= (f3_q == 3'd0) ? acc_q[31:0] : acc_q[63:32];
						end
					end else begin
						if (mplier_q[0]) begin
							acc_q <= acc_q + mcand_q;
						end
						mcand_q  <= {mcand_q[62:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[31:1]};
						cnt_q <= cnt_q + 6'd1;
					end
				end else begin
					if (cnt_q[5]) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						if (bzero_q) begin
							res_q <= f3_q[1] ? a_q : 32'hFFFF_FFFF;
						end else if (f3_q[1]) begin
							res_q <= (negr_q && f3_q == 3'd6) ? (32'd0 - rem_q) : rem_q;
						end else begin
							res_q <= (negq_q && f3_q == 3'd4) ? (32'd0 - quo_q) : quo_q;
						end
					end else begin
						if (!trial[33]) begin
							rem_q <= trial[31:0];
							quo_q <= {quo_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh[31:0];
							quo_q <= {quo_q[30:0], 1'b0};
						end
						cnt_q <= cnt_q + 6'd1;
					end
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;
endmodule
